// ===== hdl/cst_element_stiffness_core_defines.svh =====
// Assertion macros for the CST element stiffness core.
`ifndef CST_ELEMENT_STIFFNESS_CORE_DEFINES_SVH
`define CST_ELEMENT_STIFFNESS_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CST_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cst_pkg.sv =====
// Types and constants shared by the CST element stiffness core.
package cst_pkg;

  localparam int COORD_W  = 32;   // corner coordinate
  localparam int E_W      = 40;   // Young's modulus register
  localparam int PR_W     = 15;   // Poisson ratio register
  localparam int TH_W     = 32;   // thickness register
  localparam int DIFF_W   = 33;   // coordinate difference
  localparam int PROD_W   = 66;   // product of two differences
  localparam int AREA_W   = 67;   // twice the signed area
  localparam int AMAG_W   = 66;   // magnitude of twice the area
  localparam int TE_W     = 72;   // thickness times modulus
  localparam int TE_CW    = 24;   // te chunk for partial products
  localparam int TE_CN    = 3;
  localparam int AC_CW    = 32;   // numerator chunk for partial products
  localparam int LD_CW    = 22;   // area chunk for the divisor multiply
  localparam int LD_CN    = 3;
  localparam int LD_CNT_W = 2;
  localparam int Q_W      = 48;   // quotient bits kept before saturation
  localparam int VAL_W    = 48;

  localparam logic [2:0]       DOF_LAST = 3'd5;
  localparam logic [VAL_W-1:0] VAL_POS  = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_NEG  = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    REG_YOUNGS  = 2'd0,
    REG_POISSON = 2'd1,
    REG_THICK   = 2'd2
  } cst_reg_t;

  // Per-entry side information that travels down the pipeline
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
    logic       degen;
    logic       neg;
    logic       same;
    logic       big;
  } cst_meta_t;

endpackage

// ===== hdl/cst_element_stiffness_core.sv =====
// CST plane-stress element stiffness core: config, loader, entry pipeline.
//
// Input channel in_*: one triangle per item, six signed corner coordinates.
// Output channel out_*: 36 stiffness entries per triangle in row-major
// order; tlast marks row 5 column 5, tuser flags a zero-area triangle
// (all values then zero). Values saturate to 48 signed bits.
// Config channel cfg_*: index 0 modulus, 1 Poisson ratio, 2 thickness;
// other indexes are ignored. Write only while the block is idle.
// Throughput: one entry per cycle while the output does not stall; the
// entry counter that walks the 36 matrix positions sets this. A loader
// prepares the next triangle (differences, area, divisor) while the
// current one streams out.
// From accept to the first valid entry: the loader, the entry counter
// start, then the register stages (operand select, products, weights,
// sum, 9 partial-product stages, range check, a 48-stage pipelined
// restoring divider, output register).
// Reset: synchronous, active low; empties the pipeline, restores the
// register defaults (modulus 1.0, ratio 0, thickness 1.0).
// Stall: when out_tvalid is high and out_tready low the whole entry pipeline
// holds; the loader may still take one more triangle and waits with it.
`include "cst_element_stiffness_core_defines.svh"

module cst_element_stiffness_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y (32 bits each)
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // matrix_row[2:0], matrix_col[5:3], stiffness_value[53:6], zero pad
  output logic [55:0]  out_tdata,
  // degenerate
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [39:0]  cfg_data
);

  localparam int AW     = FRAC_BITS + 68;
  localparam int AMW    = AW - 1;
  localparam int DCW    = 2 * FRAC_BITS + 3;
  localparam int DENW   = DCW + cst_pkg::AMAG_W;
  localparam int ACN    = (AMW + cst_pkg::AC_CW - 1) / cst_pkg::AC_CW;
  localparam int MCH    = ACN * cst_pkg::TE_CN;
  localparam int NW     = AMW + cst_pkg::TE_W;
  localparam int XW     = (NW > DENW + cst_pkg::Q_W) ? NW : DENW + cst_pkg::Q_W;
  localparam int W22W   = FRAC_BITS + 1;
  localparam int PPW    = cst_pkg::AC_CW + cst_pkg::TE_CW;
  localparam int S_PROD = 1;
  localparam int S_SCAL = 2;
  localparam int S_ACC  = 3;
  localparam int S_MUL0 = 4;
  localparam int S_CHK  = S_MUL0 + MCH;
  localparam int S_DIV0 = S_CHK + 1;
  localparam int S_OUT  = S_DIV0 + cst_pkg::Q_W;
  localparam int NS     = S_OUT + 1;

  // ---------------- configuration registers ----------------
  logic [cst_pkg::E_W-1:0]  ym_r;
  logic [cst_pkg::PR_W-1:0] pr_r;
  logic [cst_pkg::TH_W-1:0] th_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ym_r <= cst_pkg::E_W'(64'd1 << FRAC_BITS);
      pr_r <= '0;
      th_r <= cst_pkg::TH_W'(64'd1 << FRAC_BITS);
    end else if (cfg_valid) begin
      case (cfg_index)
        cst_pkg::REG_YOUNGS:  ym_r <= cfg_data;
        cst_pkg::REG_POISSON: pr_r <= cfg_data[cst_pkg::PR_W-1:0];
        cst_pkg::REG_THICK:   th_r <= cfg_data[cst_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- derived constants, two register stages ----------------
  logic [cst_pkg::PR_W-1:0] nc_nxt, nc_r;
  logic [63:0]              telo_r;
  logic [39:0]              tehi_r;
  logic [cst_pkg::TE_W-1:0] te_r;
  logic [cst_pkg::PR_W:0]   w01_r;
  logic [W22W-1:0]          w22_r;
  logic [DCW-1:0]           denc_r;

  // clamp the ratio below one
  always_comb begin
    nc_nxt = pr_r;
    if (64'(pr_r) >= (64'd1 << FRAC_BITS))
      nc_nxt = cst_pkg::PR_W'((64'd1 << FRAC_BITS) - 64'd1);
  end

  always_ff @(posedge clk) begin
    nc_r   <= nc_nxt;
    telo_r <= 64'(ym_r[31:0]) * 64'(th_r);
    tehi_r <= 40'(ym_r[39:32]) * 40'(th_r);
    te_r   <= cst_pkg::TE_W'(telo_r) + (cst_pkg::TE_W'(tehi_r) << 32);
    w01_r  <= {nc_r, 1'b0};
    w22_r  <= W22W'((64'd1 << FRAC_BITS) - 64'(nc_r));
    denc_r <= DCW'(((64'd1 << (2 * FRAC_BITS)) - 64'(nc_r) * 64'(nc_r)) << 2);
  end

  // ---------------- loader: differences, area, divisor ----------------
  typedef enum logic [2:0] {
    LD_IDLE, LD_DIFF, LD_MUL1, LD_MUL2, LD_AREA, LD_DEN, LD_READY
  } ld_state_t;

  ld_state_t                          ld_state_r;
  logic signed [cst_pkg::COORD_W-1:0] crd_r [6];
  logic signed [cst_pkg::DIFF_W-1:0]  lxd_r [3];
  logic signed [cst_pkg::DIFF_W-1:0]  lyd_r [3];
  logic signed [cst_pkg::PROD_W-1:0]  lp1_r, lp2_r;
  logic signed [cst_pkg::AREA_W-1:0]  area_nxt;
  logic                               larea_neg_r, ldegen_r;
  logic [cst_pkg::AMAG_W-1:0]         lam_r;
  logic [DENW-1:0]                    lden_r;
  logic [cst_pkg::LD_CNT_W-1:0]       lcnt_r;
  logic                               gen_load;

  assign in_tready = (ld_state_r == LD_IDLE);
  assign area_nxt  = cst_pkg::AREA_W'(lp1_r) - cst_pkg::AREA_W'(lp2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_state_r <= LD_IDLE;
    end else begin
      case (ld_state_r)
        LD_IDLE: begin
          if (in_tvalid) begin
            for (int k = 0; k < 6; k++)
              crd_r[k] <= in_tdata[k*cst_pkg::COORD_W +: cst_pkg::COORD_W];
            ld_state_r <= LD_DIFF;
          end
        end
        LD_DIFF: begin
          lxd_r[0] <= cst_pkg::DIFF_W'(crd_r[4]) - cst_pkg::DIFF_W'(crd_r[2]);
          lxd_r[1] <= cst_pkg::DIFF_W'(crd_r[0]) - cst_pkg::DIFF_W'(crd_r[4]);
          lxd_r[2] <= cst_pkg::DIFF_W'(crd_r[2]) - cst_pkg::DIFF_W'(crd_r[0]);
          lyd_r[0] <= cst_pkg::DIFF_W'(crd_r[3]) - cst_pkg::DIFF_W'(crd_r[5]);
          lyd_r[1] <= cst_pkg::DIFF_W'(crd_r[5]) - cst_pkg::DIFF_W'(crd_r[1]);
          lyd_r[2] <= cst_pkg::DIFF_W'(crd_r[1]) - cst_pkg::DIFF_W'(crd_r[3]);
          ld_state_r <= LD_MUL1;
        end
        LD_MUL1: begin
          lp1_r <= cst_pkg::PROD_W'(lxd_r[2]) * cst_pkg::PROD_W'(lyd_r[1]);
          ld_state_r <= LD_MUL2;
        end
        LD_MUL2: begin
          lp2_r <= cst_pkg::PROD_W'(lxd_r[1]) * cst_pkg::PROD_W'(lyd_r[2]);
          ld_state_r <= LD_AREA;
        end
        LD_AREA: begin
          larea_neg_r <= area_nxt[cst_pkg::AREA_W-1];
          ldegen_r    <= (area_nxt == '0);
          lam_r       <= cst_pkg::AMAG_W'(area_nxt[cst_pkg::AREA_W-1] ? -area_nxt : area_nxt);
          lden_r      <= '0;
          lcnt_r      <= '0;
          ld_state_r  <= LD_DEN;
        end
        LD_DEN: begin
          // divisor = denc * |area|, high chunk first
          lden_r <= (lden_r << cst_pkg::LD_CW)
                  + DENW'(lam_r[cst_pkg::AMAG_W-1 -: cst_pkg::LD_CW] * denc_r);
          lam_r  <= lam_r << cst_pkg::LD_CW;
          lcnt_r <= lcnt_r + 1'b1;
          if (lcnt_r == cst_pkg::LD_CNT_W'(cst_pkg::LD_CN - 1))
            ld_state_r <= LD_READY;
        end
        LD_READY: begin
          if (gen_load) ld_state_r <= LD_IDLE;
        end
        default: ld_state_r <= LD_IDLE;
      endcase
    end
  end

  // ---------------- entry generator ----------------
  logic                              en;
  logic                              gen_active_r, gen_last;
  logic [2:0]                        gen_row_r, gen_col_r;
  logic signed [cst_pkg::DIFF_W-1:0] gxd_r [3];
  logic signed [cst_pkg::DIFF_W-1:0] gyd_r [3];
  logic                              gneg_r, gdegen_r;
  logic [DENW-1:0]                   gden_r;

  assign en       = !out_tvalid || out_tready;
  assign gen_last = (gen_row_r == cst_pkg::DOF_LAST) && (gen_col_r == cst_pkg::DOF_LAST);
  assign gen_load = (ld_state_r == LD_READY) && (!gen_active_r || (en && gen_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_active_r <= 1'b0;
      gen_row_r    <= '0;
      gen_col_r    <= '0;
    end else if (gen_load) begin
      gen_active_r <= 1'b1;
      gen_row_r    <= '0;
      gen_col_r    <= '0;
      gxd_r        <= lxd_r;
      gyd_r        <= lyd_r;
      gneg_r       <= larea_neg_r;
      gdegen_r     <= ldegen_r;
      gden_r       <= lden_r;
    end else if (en && gen_active_r) begin
      if (gen_last) begin
        gen_active_r <= 1'b0;
      end else if (gen_col_r == cst_pkg::DOF_LAST) begin
        gen_col_r <= '0;
        gen_row_r <= gen_row_r + 1'b1;
      end else begin
        gen_col_r <= gen_col_r + 1'b1;
      end
    end
  end

  // ---------------- pipeline valid and side data ----------------
  logic                v_r      [NS];
  cst_pkg::cst_meta_t  meta_r   [NS];
  cst_pkg::cst_meta_t  meta_nxt [NS];
  logic [DENW-1:0]     den_r    [S_OUT-1];
  cst_pkg::cst_meta_t  meta0_nxt;
  logic signed [AW-1:0] acc_nxt;
  logic                 big_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= gen_active_r;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_comb begin
    meta0_nxt.row   = gen_row_r;
    meta0_nxt.col   = gen_col_r;
    meta0_nxt.last  = gen_last;
    meta0_nxt.degen = gdegen_r;
    meta0_nxt.neg   = gneg_r;
    meta0_nxt.same  = (gen_row_r[0] == gen_col_r[0]);
    meta0_nxt.big   = 1'b0;
  end

  // shift the side data; the sum stage folds in the numerator sign and the
  // check stage adds the range flag
  always_comb begin
    meta_nxt[0] = meta0_nxt;
    for (int k = 1; k < NS; k++) meta_nxt[k] = meta_r[k-1];
    meta_nxt[S_ACC].neg = meta_r[S_ACC-1].neg ^ acc_nxt[AW-1];
    meta_nxt[S_CHK].big = big_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) meta_r[k] <= meta_nxt[k];
      den_r[0] <= gden_r;
      for (int k = 1; k < S_OUT - 1; k++) den_r[k] <= den_r[k-1];
    end
  end

  // ---------------- stage 0: operand select ----------------
  // the sparse B rows make both first products a single term sv(i)*sv(j)
  logic signed [cst_pkg::DIFF_W-1:0] opa_r, opb_r, opc_r, opd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      opa_r <= gen_row_r[0] ? gxd_r[gen_row_r[2:1]] : gyd_r[gen_row_r[2:1]];
      opb_r <= gen_col_r[0] ? gxd_r[gen_col_r[2:1]] : gyd_r[gen_col_r[2:1]];
      opc_r <= gen_row_r[0] ? gyd_r[gen_row_r[2:1]] : gxd_r[gen_row_r[2:1]];
      opd_r <= gen_col_r[0] ? gyd_r[gen_col_r[2:1]] : gxd_r[gen_col_r[2:1]];
    end
  end

  // ---------------- products, weights, sum ----------------
  logic signed [cst_pkg::PROD_W-1:0] p1_r, p2_r;
  logic signed [AW-1:0]              p1x, p2x, w01x, w22x, t1_nxt, t2_nxt;
  logic signed [AW-1:0]              t1_r, t2_r;
  logic [AMW-1:0]                    accm_r [MCH];

  always_comb begin
    p1x    = AW'(p1_r);
    p2x    = AW'(p2_r);
    w01x   = AW'(w01_r);
    w22x   = AW'(w22_r);
    t1_nxt = meta_r[S_PROD].same ? (p1x <<< (FRAC_BITS + 1)) : p1x * w01x;
    t2_nxt = p2x * w22x;
    acc_nxt = t1_r + t2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r      <= cst_pkg::PROD_W'(opa_r) * cst_pkg::PROD_W'(opb_r);
      p2_r      <= cst_pkg::PROD_W'(opc_r) * cst_pkg::PROD_W'(opd_r);
      t1_r      <= t1_nxt;
      t2_r      <= t2_nxt;
      accm_r[0] <= AMW'(acc_nxt[AW-1] ? -acc_nxt : acc_nxt);
    end
  end

  // ---------------- numerator times te, one partial product a stage ----------------
  logic [NW-1:0] sum_r [MCH];

  for (genvar gk = 0; gk < MCH; gk++) begin : g_mul
    localparam int CA = gk / cst_pkg::TE_CN;
    localparam int CB = gk % cst_pkg::TE_CN;
    localparam int SH = CA * cst_pkg::AC_CW + CB * cst_pkg::TE_CW;
    logic [ACN*cst_pkg::AC_CW-1:0] apad;
    logic [PPW-1:0]                pp;
    assign apad = (ACN*cst_pkg::AC_CW)'(accm_r[gk]);
    assign pp   = PPW'(apad[CA*cst_pkg::AC_CW +: cst_pkg::AC_CW])
                * PPW'(te_r[CB*cst_pkg::TE_CW +: cst_pkg::TE_CW]);
    if (gk == 0) begin : g_first
      always_ff @(posedge clk) if (en) sum_r[gk] <= NW'(pp) << SH;
    end else begin : g_next
      always_ff @(posedge clk) if (en) sum_r[gk] <= sum_r[gk-1] + (NW'(pp) << SH);
    end
    if (gk < MCH - 1) begin : g_carry
      always_ff @(posedge clk) if (en) accm_r[gk+1] <= accm_r[gk];
    end
  end

  // ---------------- overflow check and divider entry ----------------
  logic [DENW-1:0]         rem_r [cst_pkg::Q_W+1];
  logic [cst_pkg::Q_W-1:0] nlo_r [cst_pkg::Q_W];
  logic [cst_pkg::Q_W-1:0] q_r   [cst_pkg::Q_W+1];

  assign big_nxt = XW'(sum_r[MCH-1]) >= (XW'(den_r[S_CHK-1]) << cst_pkg::Q_W);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DENW'(sum_r[MCH-1] >> cst_pkg::Q_W);
      nlo_r[0] <= sum_r[MCH-1][cst_pkg::Q_W-1:0];
      q_r[0]   <= '0;
    end
  end

  // ---------------- restoring divider, one quotient bit a stage ----------------
  for (genvar gd = 0; gd < cst_pkg::Q_W; gd++) begin : g_div
    logic [DENW:0] trial;
    logic          ge;
    assign trial = {rem_r[gd], nlo_r[gd][cst_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, den_r[S_DIV0+gd-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gd+1] <= DENW'(ge ? trial - {1'b0, den_r[S_DIV0+gd-1]} : trial);
        q_r[gd+1]   <= {q_r[gd][cst_pkg::Q_W-2:0], ge};
      end
    end
    if (gd < cst_pkg::Q_W - 1) begin : g_shift
      always_ff @(posedge clk) if (en) nlo_r[gd+1] <= nlo_r[gd] << 1;
    end
  end

  // ---------------- saturate and sign, output register ----------------
  logic [cst_pkg::VAL_W-1:0] val_nxt, val_r, mneg;
  cst_pkg::cst_meta_t        mo;

  assign mo = meta_r[S_OUT-1];

  always_comb begin
    mneg = cst_pkg::VAL_NEG;
    if (!mo.big && q_r[cst_pkg::Q_W] <= cst_pkg::VAL_NEG)
      mneg = q_r[cst_pkg::Q_W];
    if (mo.degen)
      val_nxt = '0;
    else if (mo.neg)
      val_nxt = -mneg;
    else if (mo.big || q_r[cst_pkg::Q_W] > cst_pkg::VAL_POS)
      val_nxt = cst_pkg::VAL_POS;
    else
      val_nxt = q_r[cst_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (en) val_r <= val_nxt;
  end

  assign out_tvalid   = v_r[S_OUT];
  assign out_tdata    = {2'b00, val_r, meta_r[S_OUT].col, meta_r[S_OUT].row};
  assign out_tuser[0] = meta_r[S_OUT].degen;
  assign out_tlast    = meta_r[S_OUT].last;

  // ---------------- assertions ----------------
  `CST_ASSERT(a_degen_zero, out_tvalid && out_tuser[0], out_tdata[53:6] == '0, "degenerate entry carries a value")
  `CST_ASSERT_NEXT(a_gen_hold, gen_active_r && !en, $stable(gen_row_r) && $stable(gen_col_r), "entry counter moved in a stall")
  `CST_ASSERT(a_gen_range, gen_active_r, gen_row_r <= cst_pkg::DOF_LAST && gen_col_r <= cst_pkg::DOF_LAST, "entry counter out of range")

endmodule
